FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// clocked checks shared by the decoder modules, using clk and rst in scope
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RPD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RPD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/rpd_pkg.sv
// ----------------------------------------------------------------------------
// rpd_pkg
// types and constants of the four-channel rc pulse decoder
// ----------------------------------------------------------------------------
package rpd_pkg;

  // timer and arithmetic widths
  localparam int TIMER_BITS = 16;
  localparam int VAL_W      = 16;
  localparam int WIDTH_W    = (TIMER_BITS > VAL_W) ? TIMER_BITS : VAL_W;
  localparam int PROD_W     = WIDTH_W + VAL_W;
  localparam int QCNT_W     = $clog2(PROD_W);
  localparam int NUM_CH     = 4;
  localparam int CH_W       = 2;
  localparam int CFG_IDX_W  = 3;

  localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_RANGE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_OUT_MIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_OUT_SPAN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTITUDE_MIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTITUDE_RANGE = 3'd5;

  // channel codes
  localparam logic [CH_W-1:0] CH_THROTTLE = 2'd0;

  // reset values of the configuration registers
  localparam logic [VAL_W-1:0] RST_PULSE_MIN   = 16'd1000;
  localparam logic [VAL_W-1:0] RST_PULSE_RANGE = 16'd1000;
  localparam logic [VAL_W-1:0] RST_OUT_MIN     = 16'd0;
  localparam logic [VAL_W-1:0] RST_OUT_RANGE   = 16'd1000;

  typedef struct packed {
    logic [CH_W-1:0]  channel;
    logic             pin_high;
    logic [15:0]      capture_time;
  } rpd_in_t;

  typedef struct packed {
    logic [VAL_W-1:0] throttle_value;
    logic [VAL_W-1:0] roll_value;
    logic [VAL_W-1:0] yaw_value;
    logic [VAL_W-1:0] pitch_value;
  } rpd_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } rpd_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic mul;
    logic div_step;
    logic commit;
  } rpd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_last;
    logic commit_ok;
  } rpd_status_t;

endpackage

FILE: hw/rtl/rpd_ctrl.sv
// ----------------------------------------------------------------------------
// rpd_ctrl
// sequencer: accept, multiply, serial divide, commit
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rpd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                pin_high,
  input  rpd_pkg::rpd_status_t status,
  output logic                in_stall,
  output rpd_pkg::rpd_cmd_t   cmd
);

  rpd_pkg::rpd_state_t state;
  rpd_pkg::rpd_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rpd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      rpd_pkg::ST_IDLE: begin
        if (in_valid && !pin_high) state_next = rpd_pkg::ST_MUL;
      end
      rpd_pkg::ST_MUL: begin
        state_next = rpd_pkg::ST_DIV;
      end
      rpd_pkg::ST_DIV: begin
        if (status.div_last) state_next = rpd_pkg::ST_DONE;
      end
      rpd_pkg::ST_DONE: begin
        if (status.commit_ok) state_next = rpd_pkg::ST_IDLE;
      end
      default: state_next = rpd_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall     = 1'b1;
    cmd          = '0;
    unique case (state)
      rpd_pkg::ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      rpd_pkg::ST_MUL:  cmd.mul      = 1'b1;
      rpd_pkg::ST_DIV:  cmd.div_step = 1'b1;
      rpd_pkg::ST_DONE: cmd.commit   = status.commit_ok;
      default: in_stall = 1'b1;
    endcase
  end

  // a falling edge runs the full sequence, a rising edge finishes at accept
  `RPD_ASSERT_NXT(a_fall_to_mul, cmd.accept && !pin_high, state == rpd_pkg::ST_MUL, "falling edge did not start multiply")
  `RPD_ASSERT_NXT(a_div_to_done, state == rpd_pkg::ST_DIV && status.div_last, state == rpd_pkg::ST_DONE, "divide end missed")
  `RPD_ASSERT_NXT(a_commit_idle, cmd.commit, state == rpd_pkg::ST_IDLE && !in_stall, "commit did not return to idle")

endmodule

FILE: hw/rtl/rpd_dp.sv
// ----------------------------------------------------------------------------
// rpd_dp
// datapath: config registers, per-channel state, multiplier, serial divider
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rpd_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  rpd_pkg::rpd_in_t     in_data,
  input  rpd_pkg::rpd_cmd_t    cmd,
  output rpd_pkg::rpd_status_t status,
  input  logic                 cfg_valid,
  input  logic [rpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rpd_pkg::VAL_W-1:0]     cfg_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rpd_pkg::rpd_out_t    out_data
);

  // configuration registers
  logic [rpd_pkg::VAL_W-1:0] pulse_min;
  logic [rpd_pkg::VAL_W-1:0] pulse_range;
  logic [rpd_pkg::VAL_W-1:0] thr_out_min;
  logic [rpd_pkg::VAL_W-1:0] thr_out_span;
  logic [rpd_pkg::VAL_W-1:0] attitude_min;
  logic [rpd_pkg::VAL_W-1:0] attitude_range;

  // per-channel state
  logic [rpd_pkg::TIMER_BITS-1:0] rise_stamp [rpd_pkg::NUM_CH];
  logic [rpd_pkg::VAL_W-1:0]      channel_value [rpd_pkg::NUM_CH];
  logic [rpd_pkg::NUM_CH-1:0]     channel_valid;

  // working registers of one falling edge
  logic [rpd_pkg::CH_W-1:0]       ch;
  logic [rpd_pkg::TIMER_BITS-1:0] width;
  logic                           short_pulse;
  logic [rpd_pkg::VAL_W-1:0]      rem;
  logic [rpd_pkg::PROD_W-1:0]     quo;
  logic [rpd_pkg::QCNT_W-1:0]     div_cnt;

  logic [rpd_pkg::TIMER_BITS-1:0] stamp_in;
  logic [rpd_pkg::WIDTH_W-1:0]    width_ext;
  logic [rpd_pkg::WIDTH_W-1:0]    pmin_ext;
  logic [rpd_pkg::VAL_W-1:0]      out_min;
  logic [rpd_pkg::VAL_W-1:0]      out_range;
  logic [rpd_pkg::VAL_W:0]        rem_shift;
  logic                           rem_ge;
  logic [rpd_pkg::VAL_W:0]        sum;
  logic [rpd_pkg::VAL_W-1:0]      value;
  logic [rpd_pkg::NUM_CH-1:0]     valid_next;
  logic                           all_valid;
  logic                           out_free;
  logic                           emit;
  logic                           rise_take;
  logic [rpd_pkg::VAL_W-1:0]      value_mix [rpd_pkg::NUM_CH];

  // config write port, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_min      <= rpd_pkg::RST_PULSE_MIN;
      pulse_range    <= rpd_pkg::RST_PULSE_RANGE;
      thr_out_min    <= rpd_pkg::RST_OUT_MIN;
      thr_out_span   <= rpd_pkg::RST_OUT_RANGE;
      attitude_min   <= rpd_pkg::RST_OUT_MIN;
      attitude_range <= rpd_pkg::RST_OUT_RANGE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rpd_pkg::CFG_PULSE_MIN:      pulse_min      <= cfg_data;
        rpd_pkg::CFG_PULSE_RANGE:    pulse_range    <= cfg_data;
        rpd_pkg::CFG_THR_OUT_MIN:    thr_out_min    <= cfg_data;
        rpd_pkg::CFG_THR_OUT_SPAN:   thr_out_span   <= cfg_data;
        rpd_pkg::CFG_ATTITUDE_MIN:   attitude_min   <= cfg_data;
        rpd_pkg::CFG_ATTITUDE_RANGE: attitude_range <= cfg_data;
        default: ;
      endcase
    end
  end

  // operand selection
  assign stamp_in  = rpd_pkg::TIMER_BITS'(in_data.capture_time);
  assign width_ext = rpd_pkg::WIDTH_W'(width);
  assign pmin_ext  = rpd_pkg::WIDTH_W'(pulse_min);
  assign out_min   = (ch == rpd_pkg::CH_THROTTLE) ? thr_out_min : attitude_min;
  assign out_range = (ch == rpd_pkg::CH_THROTTLE) ? thr_out_span : attitude_range;

  // restoring divide step
  assign rem_shift = {rem, quo[rpd_pkg::PROD_W-1]};
  assign rem_ge    = rem_shift >= {1'b0, pulse_range};

  // final value: short pulses give the output minimum, overflow and a zero range saturate
  assign sum = {1'b0, out_min} + {1'b0, quo[rpd_pkg::VAL_W-1:0]};
  always_comb begin
    priority if (pulse_range == '0) begin
      value = rpd_pkg::VAL_MAX;
    end else if (short_pulse) begin
      value = out_min;
    end else if (|quo[rpd_pkg::PROD_W-1:rpd_pkg::VAL_W] || sum[rpd_pkg::VAL_W]) begin
      value = rpd_pkg::VAL_MAX;
    end else begin
      value = sum[rpd_pkg::VAL_W-1:0];
    end
  end

  // flags and values as they stand after commit
  assign valid_next = channel_valid | (rpd_pkg::NUM_CH'(1) << ch);
  assign all_valid  = &valid_next;
  assign out_free   = !out_valid || !out_stall;
  assign emit       = cmd.commit && all_valid;
  assign rise_take  = cmd.accept && in_data.pin_high;
  always_comb begin
    for (int i = 0; i < rpd_pkg::NUM_CH; i++) begin
      value_mix[i] = (ch == rpd_pkg::CH_W'(i)) ? value : channel_value[i];
    end
  end

  assign status.div_last  = div_cnt == rpd_pkg::QCNT_W'(rpd_pkg::PROD_W - 1);
  assign status.commit_ok = out_free || !all_valid;

  // capture stage and per-channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_valid <= '0;
      for (int i = 0; i < rpd_pkg::NUM_CH; i++) begin
        rise_stamp[i]    <= '0;
        channel_value[i] <= '0;
      end
    end else begin
      if (rise_take) begin
        rise_stamp[in_data.channel]    <= stamp_in;
        channel_valid[in_data.channel] <= 1'b0;
      end
      if (cmd.commit) begin
        channel_value[ch] <= value;
        channel_valid[ch] <= 1'b1;
      end
    end
  end

  // working registers: width, product, divider
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ch    <= in_data.channel;
      width <= stamp_in - rise_stamp[in_data.channel];
    end
    if (cmd.mul) begin
      short_pulse <= width_ext < pmin_ext;
      quo         <= rpd_pkg::PROD_W'(width_ext - pmin_ext) * rpd_pkg::PROD_W'(out_range);
      rem         <= '0;
      div_cnt     <= '0;
    end else if (cmd.div_step) begin
      rem     <= rem_ge ? rpd_pkg::VAL_W'(rem_shift - {1'b0, pulse_range})
                        : rem_shift[rpd_pkg::VAL_W-1:0];
      quo     <= {quo[rpd_pkg::PROD_W-2:0], rem_ge};
      div_cnt <= div_cnt + rpd_pkg::QCNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.throttle_value <= value_mix[0];
      out_data.roll_value     <= value_mix[1];
      out_data.yaw_value      <= value_mix[2];
      out_data.pitch_value    <= value_mix[3];
    end
  end

  `RPD_ASSERT_NXT(a_emit_on_full, emit, out_valid && (&channel_valid), "full set did not emit")
  `RPD_ASSERT_NXT(a_rise_clears, rise_take, !channel_valid[ch], "rising edge left channel valid")
  `RPD_ASSERT_IMP(a_commit_free, emit, out_free, "commit overwrote a pending beat")

endmodule

FILE: hw/rtl/rc_pwm_four_channel_decoder.sv
// ----------------------------------------------------------------------------
// rc_pwm_four_channel_decoder
// four-channel rc pulse-width decoder with scaling and saturation
// ----------------------------------------------------------------------------
// rising edge: taken in idle, next beat accepted the cycle after
// falling edge: capture, 16x16 multiply, the one-bit restoring divider,
//   commit (held while a result waits in the stalled output); the serial divider sets the rate
// a result beat waits in an output register while the next edge is taken
// rst (synchronous): config to defaults, stamps and values zero, no channel valid
module rc_pwm_four_channel_decoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  rpd_pkg::rpd_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output rpd_pkg::rpd_out_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rpd_pkg::VAL_W-1:0]     cfg_data
);

  rpd_pkg::rpd_cmd_t    cmd;
  rpd_pkg::rpd_status_t status;

  // config writes land at once
  assign cfg_ready = 1'b1;

  rpd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .pin_high (in_data.pin_high),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  rpd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: test/rc_pwm_four_channel_decoder_checker.sv
// ----------------------------------------------------------------------------
// rc_pwm_four_channel_decoder_checker
// watches the capture, result and register channels of the pulse decoder,
// keeps its own copy of the stamps, commands and settings, and compares every
// result beat with the oldest predicted command set
// ----------------------------------------------------------------------------
module rc_pwm_four_channel_decoder_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  rpd_pkg::rpd_in_t              in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  rpd_pkg::rpd_out_t             out_data,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [rpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rpd_pkg::VAL_W-1:0]     cfg_data,
  output int                            fail_count,
  output int                            pending_results
);

  // settings as written through the register port
  logic [15:0] width_floor;
  logic [15:0] width_span;
  logic [15:0] thr_base;
  logic [15:0] thr_span;
  logic [15:0] att_base;
  logic [15:0] att_span;

  // per-channel capture state
  logic [15:0] rise_capture [4];
  logic [15:0] command_value [4];
  logic [3:0]  command_ready;

  rpd_pkg::rpd_out_t expected_commands [$];
  rpd_pkg::rpd_out_t want;
  rpd_pkg::rpd_out_t fresh;
  logic [1:0]        ch;
  logic [15:0]       pulse_ticks;
  int                mismatch_total = 0;
  int                waiting = 0;

  assign fail_count      = mismatch_total;
  assign pending_results = waiting;

  task automatic report_mismatch(input string msg);
    if (mismatch_total < 40) $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_total++;
  endtask

  // width to command: offset, exact product over the span, saturated
  function automatic logic [15:0] scaled_command(input logic [15:0] ticks,
                                                 input logic [15:0] out_base,
                                                 input logic [15:0] out_span);
    logic [31:0] quotient;
    logic [32:0] total;
    if (width_span == 16'd0) return 16'hFFFF;
    if (ticks < width_floor) return out_base;
    quotient = (32'(ticks - width_floor) * 32'(out_span)) / 32'(width_span);
    total    = {17'd0, out_base} + {1'b0, quotient};
    if (total > 33'h0FFFF) return 16'hFFFF;
    return total[15:0];
  endfunction

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, exp_val));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_floor   = rpd_pkg::RST_PULSE_MIN;
      width_span    = rpd_pkg::RST_PULSE_RANGE;
      thr_base      = rpd_pkg::RST_OUT_MIN;
      thr_span      = rpd_pkg::RST_OUT_RANGE;
      att_base      = rpd_pkg::RST_OUT_MIN;
      att_span      = rpd_pkg::RST_OUT_RANGE;
      command_ready = 4'b0000;
      for (int i = 0; i < 4; i++) begin
        rise_capture[i]  = 16'd0;
        command_value[i] = 16'd0;
      end
      expected_commands.delete();
    end else begin
      // result beat against the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_commands.size() == 0) begin
          report_mismatch($sformatf("result beat %0d/%0d/%0d/%0d with nothing expected",
                                    out_data.throttle_value, out_data.roll_value,
                                    out_data.yaw_value, out_data.pitch_value));
        end else begin
          want = expected_commands.pop_front();
          compare_field("throttle_value", out_data.throttle_value, want.throttle_value);
          compare_field("roll_value", out_data.roll_value, want.roll_value);
          compare_field("yaw_value", out_data.yaw_value, want.yaw_value);
          compare_field("pitch_value", out_data.pitch_value, want.pitch_value);
        end
      end

      // register writes, spare indexes ignored
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rpd_pkg::CFG_PULSE_MIN:      width_floor = cfg_data;
          rpd_pkg::CFG_PULSE_RANGE:    width_span  = cfg_data;
          rpd_pkg::CFG_THR_OUT_MIN:    thr_base    = cfg_data;
          rpd_pkg::CFG_THR_OUT_SPAN:   thr_span    = cfg_data;
          rpd_pkg::CFG_ATTITUDE_MIN:   att_base    = cfg_data;
          rpd_pkg::CFG_ATTITUDE_RANGE: att_span    = cfg_data;
          default: ;
        endcase
      end

      // capture beat: rising edge stores the stamp, falling edge scales
      if (in_valid && !in_stall) begin
        ch = in_data.channel;
        if (in_data.pin_high) begin
          rise_capture[ch]  = in_data.capture_time;
          command_ready[ch] = 1'b0;
        end else begin
          pulse_ticks = in_data.capture_time - rise_capture[ch];
          if (ch == rpd_pkg::CH_THROTTLE)
            command_value[ch] = scaled_command(pulse_ticks, thr_base, thr_span);
          else
            command_value[ch] = scaled_command(pulse_ticks, att_base, att_span);
          command_ready[ch] = 1'b1;
        end
        // flags stay set, so every completing edge emits again
        if (&command_ready) begin
          fresh.throttle_value = command_value[0];
          fresh.roll_value     = command_value[1];
          fresh.yaw_value      = command_value[2];
          fresh.pitch_value    = command_value[3];
          expected_commands.push_back(fresh);
        end
      end
    end
    waiting = expected_commands.size();
  end

endmodule

FILE: test/rc_pwm_four_channel_decoder_test.sv
// ----------------------------------------------------------------------------
// rc_pwm_four_channel_decoder_test
// drives capture edges and register writes into the pulse decoder: a directed
// opening, then phases of random frames and noise under several settings with
// random gaps and stalls, one long result hold; the checker gives the verdict
// ----------------------------------------------------------------------------
module rc_pwm_four_channel_decoder_test;

  localparam logic [1:0] CH_ROLL  = 2'd1;
  localparam logic [1:0] CH_YAW   = 2'd2;
  localparam logic [1:0] CH_PITCH = 2'd3;
  localparam logic PIN_RISE = 1'b1;
  localparam logic PIN_FALL = 1'b0;
  localparam logic [rpd_pkg::CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [rpd_pkg::CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES   = 400;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  rpd_pkg::rpd_in_t in_data;
  logic out_valid;
  logic out_stall;
  rpd_pkg::rpd_out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [rpd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rpd_pkg::VAL_W-1:0] cfg_data;
  int fail_count;
  int pending_results;

  // settings currently written, used to aim pulse widths
  logic [15:0] cur_floor = rpd_pkg::RST_PULSE_MIN;
  logic [15:0] cur_span  = rpd_pkg::RST_PULSE_RANGE;

  int  edges_sent = 0;
  bit  tx_calm = 1'b0;
  int  hold_requests = 0;
  int  holds_done = 0;
  int  rx_beats = 0;
  bit  rx_calm = 1'b0;
  int  rx_wait;

  rc_pwm_four_channel_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rc_pwm_four_channel_decoder_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit
  initial begin
    #(4 * 400000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // one capture beat: random gap, then hold until taken
  task automatic send_edge(input logic [1:0] ch, input logic pin, input logic [15:0] stamp);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid              = 1'b1;
    in_data.channel       = ch;
    in_data.pin_high      = pin;
    in_data.capture_time  = stamp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    edges_sent++;
    @(negedge clk);
  endtask

  task automatic write_register(input logic [rpd_pkg::CFG_IDX_W-1:0] idx,
                                input logic [15:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // wait for every result, then let a falling edge with no result finish
  task automatic drain();
    in_valid = 1'b0;
    wait (pending_results == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic configure(input logic [15:0] p_min, input logic [15:0] p_span,
                           input logic [15:0] t_min, input logic [15:0] t_span,
                           input logic [15:0] a_min, input logic [15:0] a_span);
    drain();
    write_register(rpd_pkg::CFG_PULSE_MIN, p_min);
    write_register(rpd_pkg::CFG_PULSE_RANGE, p_span);
    write_register(rpd_pkg::CFG_THR_OUT_MIN, t_min);
    write_register(rpd_pkg::CFG_THR_OUT_SPAN, t_span);
    write_register(rpd_pkg::CFG_ATTITUDE_MIN, a_min);
    write_register(rpd_pkg::CFG_ATTITUDE_RANGE, a_span);
    write_register(CFG_SPARE_6, 16'($urandom));
    write_register(CFG_SPARE_7, 16'($urandom));
    cfg_valid = 1'b0;
    cur_floor = p_min;
    cur_span  = p_span;
  endtask

  // pulse width: mostly within the span, sometimes short, long or anything
  function automatic logic [15:0] pick_width();
    case ($urandom_range(0, 9))
      0: return (cur_floor == 16'd0) ? 16'd0 : 16'($urandom_range(0, int'(cur_floor) - 1));
      1: return 16'($urandom);
      2: return 16'(int'(cur_floor) + int'(cur_span) + $urandom_range(0, 200));
      3: return cur_floor;
      default: return 16'(int'(cur_floor) + $urandom_range(0, int'(cur_span)));
    endcase
  endfunction

  // one radio frame: each channel rises and falls, in random order
  task automatic send_frame();
    logic [1:0]  order [4];
    logic [1:0]  tmp;
    logic [15:0] start;
    int          j;
    for (int i = 0; i < 4; i++) order[i] = 2'(i);
    for (int i = 3; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    tx_calm = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < 4; i++) begin
      start = 16'($urandom);
      send_edge(order[i], PIN_RISE, start);
      // contact bounce: a second rising edge restarts the pulse
      if ($urandom_range(0, 19) == 0) begin
        start = start + 16'($urandom_range(1, 50));
        send_edge(order[i], PIN_RISE, start);
      end
      send_edge(order[i], PIN_FALL, start + pick_width());
    end
  endtask

  task automatic run_phase(input int beats);
    int first;
    first = edges_sent;
    while (edges_sent - first < beats) begin
      if ($urandom_range(0, 11) == 0) begin
        // sender pause until everything is out
        in_valid = 1'b0;
        wait (pending_results == 0);
        @(negedge clk);
      end
      if ($urandom_range(0, 6) == 0) begin
        tx_calm = 1'b0;
        send_edge(2'($urandom), 1'($urandom), 16'($urandom));
      end else begin
        send_frame();
      end
    end
  endtask

  // receiver: per-beat stall draw, calm stretches, one long hold on request
  initial begin
    out_stall = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (holds_done < hold_requests) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_done++;
      end else begin
        if (rx_beats % 32 == 0) rx_calm = ($urandom_range(0, 3) == 0);
        rx_wait = rx_calm ? 0 : $urandom_range(0, 6);
        if (rx_wait > 0) begin
          out_stall = 1'b1;
          repeat (rx_wait) @(negedge clk);
        end
      end
      out_stall = 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      rx_beats++;
      @(negedge clk);
    end
  end

  // stimulus
  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = rpd_pkg::CFG_PULSE_MIN;
    cfg_data  = '0;
    repeat (3) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // directed opening under reset settings
    send_edge(rpd_pkg::CH_THROTTLE, PIN_FALL, 16'd1500);  // fall with no rise seen
    send_edge(CH_ROLL, PIN_RISE, 16'hFFF0);
    send_edge(CH_ROLL, PIN_FALL, 16'h0400);               // timer wrap
    send_edge(CH_YAW, PIN_RISE, 16'd100);
    send_edge(CH_YAW, PIN_FALL, 16'd600);                 // short pulse
    send_edge(CH_PITCH, PIN_RISE, 16'h0000);
    send_edge(CH_PITCH, PIN_FALL, 16'hFFFF);              // widest pulse, first emit
    send_edge(CH_PITCH, PIN_FALL, 16'd2000);              // emits again
    send_edge(rpd_pkg::CH_THROTTLE, PIN_RISE, 16'hFFFF);  // clears one flag
    send_edge(CH_YAW, PIN_FALL, 16'd1100);                // no emit
    send_edge(rpd_pkg::CH_THROTTLE, PIN_FALL, 16'h0000);  // wrap by one tick
    send_edge(CH_ROLL, PIN_RISE, 16'd0);
    send_edge(CH_ROLL, PIN_FALL, 16'd2000);               // top of the span
    send_edge(CH_ROLL, PIN_FALL, 16'd1000);               // bottom of the span

    // extremes: tiny divisor, full spans, highest throttle offset
    configure(16'd0, 16'd1, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
    run_phase(80);

    // zero divisor
    configure(16'hFFFF, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd0);
    run_phase(60);

    // typical settings with a long result hold while edges keep coming
    configure(16'd1000, 16'd1000, 16'd0, 16'd1000, 16'd0, 16'd1000);
    send_frame();
    hold_requests++;
    tx_calm = 1'b1;
    repeat (24) send_edge(2'($urandom), PIN_FALL, 16'($urandom));
    drain();
    run_phase(60);

    // random settings, mostly in the usual region
    repeat (5) begin
      if ($urandom_range(0, 3) == 0)
        configure(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom));
      else
        configure(16'($urandom_range(500, 2000)), 16'($urandom_range(1, 2000)),
                  16'($urandom_range(0, 2000)), 16'($urandom_range(0, 4000)),
                  16'($urandom_range(0, 2000)), 16'($urandom_range(0, 4000)));
      run_phase(80);
    end

    // highest floor and span, zero output spans
    configure(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0);
    run_phase(40);

    drain();
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
